// File: design/bpf_pkg.sv
// ----------------------------------------------------------------------------
// bpf_pkg
// shared constants, register codes and transfer types of the bit pattern finder
// ----------------------------------------------------------------------------
package bpf_pkg;

  localparam int unsigned MaxPatternBits = 64;
  localparam int unsigned PositionBits   = 32;
  localparam int unsigned CfgDataW       = 64;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned LenRegW        = 7;
  localparam int unsigned LenRegReset    = 8;
  localparam int unsigned FieldW         = 32;
  localparam int unsigned TdataInW       = 8;
  localparam int unsigned TdataOutW      = 2 * FieldW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternBits   = 2'd0,
    CfgPatternLength = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic restart;
    logic data_bit;
  } item_t;

  typedef struct packed {
    logic [FieldW-1:0] match_delta;
    logic [FieldW-1:0] match_start;
  } result_t;

endpackage

// File: design/bpf_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpf_cfg_regs
// pattern and pattern length registers, with the length clamped to 1..max
// ----------------------------------------------------------------------------
module bpf_cfg_regs #(
  parameter int unsigned MAX_PATTERN_BITS = bpf_pkg::MaxPatternBits,
  localparam int unsigned LenW = $clog2(MAX_PATTERN_BITS + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bpf_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [bpf_pkg::CfgDataW-1:0]         cfg_data_i,
  output logic [MAX_PATTERN_BITS-1:0]          pattern_o,
  output logic [LenW-1:0]                      len_o
);

  logic [MAX_PATTERN_BITS-1:0] pattern_q, pattern_d;
  logic [bpf_pkg::LenRegW-1:0] length_q, length_d;

  always_comb begin
    pattern_d = pattern_q;
    length_d  = length_q;
    if (cfg_we_i) begin
      case (bpf_pkg::cfg_reg_e'(cfg_idx_i))
        bpf_pkg::CfgPatternBits: begin
          pattern_d = cfg_data_i[MAX_PATTERN_BITS-1:0];
        end
        bpf_pkg::CfgPatternLength: begin
          length_d = cfg_data_i[bpf_pkg::LenRegW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= bpf_pkg::LenRegW'(bpf_pkg::LenRegReset);
    end else begin
      pattern_q <= pattern_d;
      length_q  <= length_d;
    end
  end

  // zero acts as one, anything above the window acts as the full window
  always_comb begin
    if (length_q == '0) begin
      len_o = LenW'(1);
    end else if (32'(length_q) > MAX_PATTERN_BITS) begin
      len_o = LenW'(MAX_PATTERN_BITS);
    end else begin
      len_o = LenW'(length_q);
    end
  end

  assign pattern_o = pattern_q;

endmodule

// File: design/bpf_in_reg.sv
// ----------------------------------------------------------------------------
// bpf_in_reg
// input register stage holding one stream bit and its restart flag
// ----------------------------------------------------------------------------
module bpf_in_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bpf_pkg::TdataInW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  logic                          advance_i,
  output logic                          valid_o,
  output bpf_pkg::item_t                item_o
);

  logic           valid_q, valid_d;
  bpf_pkg::item_t item_q;
  logic           accept;

  assign s_axis_tready = !valid_q || advance_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data_bit <= s_axis_tdata[0];
      item_q.restart  <= s_axis_tuser;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: design/bpf_core.sv
// ----------------------------------------------------------------------------
// bpf_core
// bit window, match counters and the parallel window compare
// ----------------------------------------------------------------------------
module bpf_core #(
  parameter int unsigned MAX_PATTERN_BITS = bpf_pkg::MaxPatternBits,
  parameter int unsigned POSITION_BITS    = bpf_pkg::PositionBits,
  localparam int unsigned LenW  = $clog2(MAX_PATTERN_BITS + 1),
  localparam int unsigned DiffW = (POSITION_BITS > bpf_pkg::FieldW) ?
                                  POSITION_BITS : bpf_pkg::FieldW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic                        advance_i,
  input  bpf_pkg::item_t              item_i,
  input  logic [MAX_PATTERN_BITS-1:0] pattern_i,
  input  logic [LenW-1:0]             len_i,
  output logic                        hit_o,
  output bpf_pkg::result_t            result_o
);

  logic [MAX_PATTERN_BITS-1:0] window_q, window_d;
  logic [LenW-1:0]             count_q, count_d;
  logic [POSITION_BITS-1:0]    pos_q, pos_d;
  logic [POSITION_BITS-1:0]    prev_q, prev_d;

  logic [MAX_PATTERN_BITS-1:0] eff_window, window_n, seen, want, len_mask;
  logic [LenW-1:0]             eff_count, count_n, shamt;
  logic [POSITION_BITS-1:0]    eff_pos, eff_prev, start;
  logic [DiffW-1:0]            diff;
  logic                        hit;

  always_comb begin
    // restart clears history before the bit is taken
    eff_window = item_i.restart ? '0 : window_q;
    eff_count  = item_i.restart ? '0 : count_q;
    eff_pos    = item_i.restart ? '0 : pos_q;
    eff_prev   = item_i.restart ? '0 : prev_q;

    window_n                     = eff_window >> 1;
    window_n[MAX_PATTERN_BITS-1] = item_i.data_bit;

    count_n = (eff_count != LenW'(MAX_PATTERN_BITS)) ? eff_count + LenW'(1) : eff_count;

    // newest len bits end up at the bottom, zero filled above
    shamt    = LenW'(MAX_PATTERN_BITS) - len_i;
    seen     = window_n >> shamt;
    len_mask = {MAX_PATTERN_BITS{1'b1}} >> shamt;
    want     = pattern_i & len_mask;
    hit      = (count_n >= len_i) && (seen == want);

    start = eff_pos - POSITION_BITS'(len_i) + POSITION_BITS'(1);
    diff  = DiffW'(start) - DiffW'(eff_prev);

    window_d = window_q;
    count_d  = count_q;
    pos_d    = pos_q;
    prev_d   = prev_q;
    if (advance_i) begin
      window_d = window_n;
      count_d  = hit ? '0 : count_n;
      pos_d    = (eff_pos != '1) ? eff_pos + POSITION_BITS'(1) : eff_pos;
      prev_d   = hit ? start : eff_prev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      count_q  <= '0;
      pos_q    <= '0;
      prev_q   <= '0;
    end else begin
      window_q <= window_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      prev_q   <= prev_d;
    end
  end

  assign hit_o                = valid_i && hit;
  assign result_o.match_start = bpf_pkg::FieldW'(start);
  assign result_o.match_delta = diff[bpf_pkg::FieldW-1:0];

endmodule

// File: design/bpf_out_reg.sv
// ----------------------------------------------------------------------------
// bpf_out_reg
// result register toward the master side of the stream
// ----------------------------------------------------------------------------
module bpf_out_reg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  bpf_pkg::result_t               result_i,
  output logic                           free_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bpf_pkg::TdataOutW-1:0]  m_axis_tdata
);

  logic             valid_q, valid_d;
  bpf_pkg::result_t data_q;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

// File: design/bit_pattern_finder.sv
// ----------------------------------------------------------------------------
// bit_pattern_finder
// searches a serial bit stream for a configured pattern, non-overlapping hits
// ----------------------------------------------------------------------------
// path: a hit passes the input and result registers to m_axis_tvalid_o
// throughput: one bit per cycle; input register, window compare, result register
// a result left waiting on the master side holds the next bit, hit or not
// reset: window, counters and previous start cleared, pattern zero, length eight
// ----------------------------------------------------------------------------
module bit_pattern_finder #(
  parameter int unsigned MAX_PATTERN_BITS = bpf_pkg::MaxPatternBits,
  parameter int unsigned POSITION_BITS    = bpf_pkg::PositionBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: [0] data_bit, zero padded to a byte
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [bpf_pkg::TdataInW-1:0]  s_axis_tdata_i,
  // tuser: [0] restart
  input  logic                          s_axis_tuser_i,
  // tdata: [31:0] match_start, [63:32] match_delta
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [bpf_pkg::TdataOutW-1:0] m_axis_tdata_o,
  input  logic                          cfg_we_i,
  input  logic [bpf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpf_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN_BITS + 1);

  logic [MAX_PATTERN_BITS-1:0] pattern;
  logic [LenW-1:0]             len;
  logic                        in_valid;
  bpf_pkg::item_t              item;
  logic                        out_free;
  logic                        advance;
  logic                        hit;
  bpf_pkg::result_t            result;

  assign advance = in_valid && out_free;

  bpf_cfg_regs #(
    .MAX_PATTERN_BITS(MAX_PATTERN_BITS)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pattern_o (pattern),
    .len_o     (len)
  );

  bpf_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid_i),
    .s_axis_tready(s_axis_tready_o),
    .s_axis_tdata (s_axis_tdata_i),
    .s_axis_tuser (s_axis_tuser_i),
    .advance_i    (advance),
    .valid_o      (in_valid),
    .item_o       (item)
  );

  bpf_core #(
    .MAX_PATTERN_BITS(MAX_PATTERN_BITS),
    .POSITION_BITS   (POSITION_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid),
    .advance_i(advance),
    .item_i   (item),
    .pattern_i(pattern),
    .len_i    (len),
    .hit_o    (hit),
    .result_o (result)
  );

  bpf_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance && hit),
    .result_i     (result),
    .free_o       (out_free),
    .m_axis_tvalid(m_axis_tvalid_o),
    .m_axis_tready(m_axis_tready_i),
    .m_axis_tdata (m_axis_tdata_o)
  );

  // a result only shows up after a hit was taken into the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(advance && hit))
  else $error("result valid without a preceding hit");

  // a taken hit is presented on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && hit |=> m_axis_tvalid_o)
  else $error("hit lost before the result register");

  // a hit on the first bit after restart can only start at position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && hit && item.restart |-> result.match_start == '0 && result.match_delta == '0)
  else $error("restart hit with nonzero start");

endmodule
